/* sv/pae_pkg.sv */
// Package of shared types, constants and codes for the per-key envelope block.
package pae_pkg;

   // Key store geometry.
   localparam int NUM_KEYS = 256;
   localparam int KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   // Field widths.
   localparam int KEY_W    = 8;
   localparam int LEVEL_W  = 8;
   localparam int TIME_W   = 16;
   localparam int PHASE_W  = 3;
   localparam int SET_W    = 8;

   // Width used to compare a key index against the key count.
   localparam int KCMP_W   = KEY_W + 3;

   // Divider numerator width: attack_setting * 10 fits in 12 bits.
   localparam int NUM_W    = 12;
   localparam int DCNT_W   = $clog2(NUM_W + 1);

   // Configuration port.
   localparam int CSR_IDX_W = 2;

   // Envelope phases as stored per key.
   typedef enum logic [PHASE_W-1:0] {
      PH_REST    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_DECAY   = 2'd1,
      CSR_RELEASE = 2'd2
   } csr_idx_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_LOAD = 2'd1,
      ST_DIV  = 2'd2,
      ST_DONE = 2'd3
   } ctrl_state_type;

   // Envelope speed settings.
   typedef struct packed {
      logic [SET_W-1:0] attack_set;
      logic [SET_W-1:0] decay_set;
      logic [SET_W-1:0] release_set;
   } settings_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic div_start;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

/* sv/pae_req_if.sv */
// Request channel: one key update per beat.
interface pae_req_if import pae_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KEY_W-1:0]   key_index;
   logic [LEVEL_W-1:0] note_level;
   logic [TIME_W-1:0]  frame_time;

   modport source (output valid, key_index, note_level, frame_time, input ready);
   modport sink   (input valid, key_index, note_level, frame_time, output ready);
endinterface

/* sv/pae_rsp_if.sv */
// Response channel: the updated intensity and phase of one key per beat.
interface pae_rsp_if import pae_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KEY_W-1:0]   key_echo;
   logic [LEVEL_W-1:0] brightness;
   logic [PHASE_W-1:0] envelope_phase;

   modport source (output valid, key_echo, brightness, envelope_phase, input ready);
   modport sink   (input valid, key_echo, brightness, envelope_phase, output ready);
endinterface

/* sv/pae_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module pae_div import pae_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  numer,
   input  logic [TIME_W-1:0] denom,
   output logic              done,
   output logic [NUM_W-1:0]  quot
);

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff,  cnt_in;
   logic [TIME_W-1:0] rem_ff,  rem_in;
   logic [NUM_W-1:0]  quo_ff,  quo_in;
   logic [TIME_W-1:0] den_ff,  den_in;
   logic [TIME_W:0]   trial;
   logic              fits;

   // One step: shift in the next numerator bit and try the subtraction.
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      fits  = (trial >= {1'b0, den_ff});
   end

   // Step control and datapath.
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = DCNT_W'(NUM_W);
         rem_in = '0;
         quo_in = numer;
         den_in = denom;
      end else if (run_ff) begin
         rem_in = fits ? TIME_W'(trial - {1'b0, den_ff}) : trial[TIME_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

/* sv/pae_ctrl.sv */
// Controller state machine sequencing read, divide and write-back of one key.
module pae_ctrl import pae_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
         end
         ST_DIV: begin
         end
         ST_DONE: begin
            cmd.commit = status.rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The divider only finishes while the controller waits for it.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   // An accepted beat always starts a store read.
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_LOAD)
      else $error("accepted beat did not start a read");

   // A blocked result holds the controller until the output register frees.
   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !status.rsp_free) |=> state_ff == ST_DONE)
      else $error("result dropped while output register was full");

endmodule

/* sv/pae_datapath.sv */
// Datapath: key store, rate divider, envelope update and output register.
module pae_datapath import pae_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_status_type status,
   input  settings_type settings,
   pae_req_if.sink      req,
   pae_rsp_if.source    rsp
);

   localparam int ENTRY_W = PHASE_W + 2 * LEVEL_W;

   // Captured request.
   logic [KEY_W-1:0]   key_ff;
   logic [LEVEL_W-1:0] note_ff;
   logic [TIME_W-1:0]  dt_ff;
   logic               oor_ff;

   // Key store with per-entry valid bits; an invalid entry reads as rest.
   logic [ENTRY_W-1:0] mem [NUM_KEYS];
   logic [NUM_KEYS-1:0] vld_ff;
   logic [ENTRY_W-1:0] rd_ff;
   logic               rd_vld_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [LEVEL_W-1:0] rsp_bright_ff;
   logic [PHASE_W-1:0] rsp_phase_ff;

   logic [ENTRY_W-1:0] entry;
   phase_type          ph_old, ph_new;
   logic [LEVEL_W-1:0] vel_old, vel_new, int_old, int_new, half;
   logic [NUM_W-1:0]   numer, rate;
   logic [NUM_W:0]     sum, floor_sum;
   logic               div_done;
   logic [KEY_AW-1:0]  rd_addr, wr_addr;
   logic               req_oor;
   logic [SET_W+2:0]   dec5, rel5;

   assign rd_addr = KEY_AW'(req.key_index);
   assign wr_addr = KEY_AW'(key_ff);
   assign req_oor = (KCMP_W'(req.key_index) >= KCMP_W'(NUM_KEYS));

   // Capture the request beat; a zero frame time counts as one.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff  <= req.key_index;
         note_ff <= req.note_level;
         dt_ff   <= (req.frame_time == '0) ? TIME_W'(1) : req.frame_time;
         oor_ff  <= req_oor;
      end
   end

   // Store read at accept, write-back at commit.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.commit && !oor_ff) begin
         mem[wr_addr] <= {ph_new, vel_new, int_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.accept) rd_vld_ff <= vld_ff[rd_addr];
         if (cmd.commit && !oor_ff) vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Unpack the stored state; unused phase codes behave as rest.
   always_comb begin
      entry   = rd_vld_ff ? rd_ff : '0;
      vel_old = entry[2*LEVEL_W-1:LEVEL_W];
      int_old = entry[LEVEL_W-1:0];
      case (entry[ENTRY_W-1:2*LEVEL_W])
         PH_ATTACK:  ph_old = PH_ATTACK;
         PH_DECAY:   ph_old = PH_DECAY;
         PH_SUSTAIN: ph_old = PH_SUSTAIN;
         PH_RELEASE: ph_old = PH_RELEASE;
         default:    ph_old = PH_REST;
      endcase
   end

   // Pick the numerator of the one rate this phase needs.
   // floor(x*5/(4*dt)) equals floor(floor(x*5/4)/dt).
   always_comb begin
      dec5 = (SET_W+3)'({settings.decay_set, 2'b00}) + (SET_W+3)'(settings.decay_set);
      rel5 = (SET_W+3)'({settings.release_set, 2'b00}) + (SET_W+3)'(settings.release_set);
      case (ph_old)
         PH_ATTACK:  numer = NUM_W'({settings.attack_set, 3'b000})
                           + NUM_W'({settings.attack_set, 1'b0});
         PH_DECAY:   numer = NUM_W'(dec5[SET_W+2:2]);
         PH_RELEASE: numer = NUM_W'(rel5[SET_W+2:2]);
         default:    numer = '0;
      endcase
   end

   pae_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .denom (dt_ff),
      .done  (div_done),
      .quot  (rate)
   );

   // Envelope update for one frame.
   always_comb begin
      ph_new    = ph_old;
      vel_new   = vel_old;
      int_new   = int_old;
      half      = vel_old >> 1;
      sum       = (NUM_W+1)'(int_old) + (NUM_W+1)'(rate);
      floor_sum = (NUM_W+1)'(half) + (NUM_W+1)'(rate);
      unique case (ph_old)
         PH_ATTACK: begin
            if (int_old < vel_old) begin
               int_new = (sum > (NUM_W+1)'(vel_old)) ? vel_old : sum[LEVEL_W-1:0];
            end else begin
               ph_new = PH_DECAY;
            end
         end
         PH_DECAY: begin
            if ({int_old, 1'b0} > {1'b0, vel_old}) begin
               int_new = ((NUM_W+1)'(int_old) >= floor_sum)
                       ? LEVEL_W'(int_old - rate[LEVEL_W-1:0]) : half;
            end else begin
               ph_new = PH_SUSTAIN;
            end
         end
         PH_SUSTAIN: begin
            if (note_ff == '0) ph_new = PH_RELEASE;
         end
         PH_RELEASE: begin
            if (note_ff != '0) begin
               ph_new  = PH_ATTACK;
               vel_new = note_ff;
            end else if (int_old != '0) begin
               int_new = (NUM_W'(int_old) > rate)
                       ? LEVEL_W'(int_old - rate[LEVEL_W-1:0]) : '0;
            end else begin
               ph_new  = PH_REST;
               vel_new = '0;
            end
         end
         default: begin
            if (note_ff != '0) begin
               ph_new  = PH_ATTACK;
               vel_new = note_ff;
            end else begin
               ph_new = PH_REST;
            end
         end
      endcase
   end

   // Output register: loaded at commit, emptied when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_key_ff    <= key_ff;
         rsp_bright_ff <= oor_ff ? '0 : int_new;
         rsp_phase_ff  <= oor_ff ? PH_REST : ph_new;
      end
   end

   assign status.div_done   = div_done;
   assign status.rsp_free   = !rsp_valid_ff || rsp.ready;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.key_echo       = rsp_key_ff;
   assign rsp.brightness     = rsp_bright_ff;
   assign rsp.envelope_phase = rsp_phase_ff;

   // A commit never overwrites a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !cmd.commit)
      else $error("output register overwritten");

endmodule

/* sv/per_key_adsr_envelope.sv */
// Top level of the per-key envelope generator: settings registers and unit wiring.
//
//  channel   direction  handshake      payload
//  req_bus   in         valid/ready    key_index, note_level, frame_time
//  rsp_bus   out        valid/ready    key_echo, brightness, envelope_phase
//  csr_*     in         write enable   csr_index, csr_wdata
//
// A beat passes from acceptance through the store read, the 12-step rate divider and
// the output register before its result is valid; the next beat is taken after that.
// Reset is synchronous and active high; all keys read as rest until written.
// A held result stalls the block in its last step; a new beat waits for the
// result before it, since only one key is in flight.
module per_key_adsr_envelope import pae_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pae_req_if.sink              req_bus,
   pae_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SET_W-1:0]     csr_wdata
);

   settings_type  settings_ff, settings_in;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Settings register writes; unknown indexes are ignored.
   always_comb begin
      settings_in = settings_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ATTACK:  settings_in.attack_set  = csr_wdata;
            CSR_DECAY:   settings_in.decay_set   = csr_wdata;
            CSR_RELEASE: settings_in.release_set = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settings_ff.attack_set  <= SET_W'(255);
         settings_ff.decay_set   <= SET_W'(128);
         settings_ff.release_set <= SET_W'(8);
      end else begin
         settings_ff <= settings_in;
      end
   end

   pae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pae_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .settings (settings_ff),
      .req      (req_bus),
      .rsp      (rsp_bus)
   );

endmodule

/* verif/tb_per_key_adsr_envelope.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the per-key envelope generator.
module tb_per_key_adsr_envelope;
   import pae_pkg::*;

   localparam int CLOCK_HALF  = 5;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 20;

   // The one register index that the block leaves unused.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // One result beat as the block should return it.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LEVEL_W-1:0] level;
      phase_type          phase;
   } envelope_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SET_W-1:0]     csr_wdata = '0;

   pae_req_if req_bus ();
   pae_rsp_if rsp_bus ();

   per_key_adsr_envelope dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the speed settings and of the key store.
   logic [SET_W-1:0]   attack_set;
   logic [SET_W-1:0]   decay_set;
   logic [SET_W-1:0]   release_set;
   phase_type          env_phase    [NUM_KEYS];
   logic [LEVEL_W-1:0] env_velocity [NUM_KEYS];
   logic [LEVEL_W-1:0] env_level    [NUM_KEYS];

   envelope_beat_type awaited_beats [$];
   int                error_count   = 0;
   int                cycle_count   = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;

   always #CLOCK_HALF clock = ~clock;

   // Advances one key by one frame in the mirror and returns the beat it should give.
   function automatic envelope_beat_type advance_envelope(input logic [KEY_W-1:0] key,
                                                          input logic [LEVEL_W-1:0] note,
                                                          input logic [TIME_W-1:0] frame_time);
      int unsigned       dt, rise, fall, fade, lvl, vel, half;
      phase_type         ph;
      envelope_beat_type beat;
      beat.key = key;
      if (int'(key) >= NUM_KEYS) begin
         beat.level = '0;
         beat.phase = PH_REST;
         return beat;
      end
      dt   = (frame_time == '0) ? 32'd1 : 32'(frame_time);
      rise = (int'(attack_set) * 10) / dt;
      fall = (int'(decay_set) * 5) / (4 * dt);
      fade = (int'(release_set) * 5) / (4 * dt);
      ph   = env_phase[key];
      vel  = 32'(env_velocity[key]);
      lvl  = 32'(env_level[key]);
      case (ph)
         PH_ATTACK: begin
            if (lvl < vel) begin
               lvl = lvl + rise;
               if (lvl > vel) lvl = vel;
            end else begin
               ph = PH_DECAY;
            end
         end
         PH_DECAY: begin
            // The sustain level is half the velocity, rounded down.
            half = vel >> 1;
            if (2 * lvl > vel) begin
               lvl = (lvl >= half + fall) ? lvl - fall : half;
            end else begin
               ph = PH_SUSTAIN;
            end
         end
         PH_SUSTAIN: begin
            if (note == '0) ph = PH_RELEASE;
         end
         PH_RELEASE: begin
            if (note != '0) begin
               ph  = PH_ATTACK;
               vel = 32'(note);
            end else if (lvl > 0) begin
               lvl = (lvl > fade) ? lvl - fade : 0;
            end else begin
               ph  = PH_REST;
               vel = 0;
            end
         end
         default: begin
            if (note != '0) begin
               ph  = PH_ATTACK;
               vel = 32'(note);
            end else begin
               ph = PH_REST;
            end
         end
      endcase
      env_phase[key]    = ph;
      env_velocity[key] = vel[LEVEL_W-1:0];
      env_level[key]    = lvl[LEVEL_W-1:0];
      beat.level = lvl[LEVEL_W-1:0];
      beat.phase = ph;
      return beat;
   endfunction

   // Mostly short frames, so that rates are large enough to move the envelope.
   function automatic logic [TIME_W-1:0] pick_frame_time();
      case ($urandom_range(0, 9))
         0:       return '0;
         7, 8:    return TIME_W'($urandom_range(9, 300));
         9:       return TIME_W'($urandom_range(0, 65535));
         default: return TIME_W'($urandom_range(1, 8));
      endcase
   endfunction

   // A zero setting stalls keys, so it is drawn only now and then.
   function automatic logic [SET_W-1:0] pick_setting();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return SET_W'($urandom_range(1, 254));
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      error_count++;
   endtask

   // Sends one beat on the request channel and records what it should produce.
   task automatic send_frame(input logic [KEY_W-1:0] key, input logic [LEVEL_W-1:0] note,
                             input logic [TIME_W-1:0] frame_time);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.key_index  = key;
      req_bus.note_level = note;
      req_bus.frame_time = frame_time;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      awaited_beats.push_back(advance_envelope(key, note, frame_time));
   endtask

   // Stops sending and waits until every expected beat has come back.
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] index, input logic [SET_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         CSR_ATTACK:  attack_set  = value;
         CSR_DECAY:   decay_set   = value;
         CSR_RELEASE: release_set = value;
         default: ;
      endcase
   endtask

   // Full envelopes through every phase with the settings left at reset.
   task automatic test_directed_envelope();
      send_frame(8'd0, 8'd255, 16'd0);
      send_frame(8'd0, 8'd255, 16'd0);
      send_frame(8'd0, 8'd200, 16'd0);
      send_frame(8'd0, 8'd255, 16'hFFFF);
      send_frame(8'd0, 8'd255, 16'd1);
      send_frame(8'd0, 8'd255, 16'd1);
      send_frame(8'd0, 8'd90, 16'd1);
      send_frame(8'd0, 8'd0, 16'd1);
      send_frame(8'd0, 8'd0, 16'd1);
      send_frame(8'd0, 8'd0, 16'd0);
      // Retrigger from release with a velocity below the current level.
      send_frame(8'd0, 8'd1, 16'd5);
      send_frame(8'd0, 8'd1, 16'd5);
      send_frame(8'd0, 8'd1, 16'd0);
      send_frame(8'd0, 8'd1, 16'd0);
      send_frame(8'd0, 8'd0, 16'd0);
      send_frame(8'd0, 8'd0, 16'd0);
      send_frame(8'd0, 8'd0, 16'd0);
      // The longest frame gives a rate of zero.
      send_frame(8'd255, 8'd128, 16'hFFFF);
      send_frame(8'd255, 8'd128, 16'hFFFF);
      send_frame(8'd255, 8'd128, 16'd0);
      send_frame(8'd170, 8'd0, 16'hAAAA);
      drain_results();
   endtask

   // The unused index is ignored; all settings are taken to both extremes.
   task automatic test_register_writes();
      write_setting(CSR_SPARE, 8'hFF);
      send_frame(8'd1, 8'd64, 16'd0);
      send_frame(8'd1, 8'd64, 16'd0);
      drain_results();
      write_setting(CSR_ATTACK, 8'h00);
      write_setting(CSR_DECAY, 8'h00);
      write_setting(CSR_RELEASE, 8'h00);
      send_frame(8'd1, 8'd64, 16'd0);
      send_frame(8'd1, 8'd64, 16'd0);
      send_frame(8'd2, 8'd200, 16'd1);
      send_frame(8'd2, 8'd200, 16'd1);
      drain_results();
      write_setting(CSR_ATTACK, 8'hFF);
      write_setting(CSR_DECAY, 8'hFF);
      write_setting(CSR_RELEASE, 8'hFF);
      for (int i = 0; i < 7; i++) send_frame(8'd2, (i == 0) ? 8'd200 : 8'd0, 16'd1);
      drain_results();
   endtask

   // Note-on and note-off runs on a few keys, mixed with unrelated beats.
   task automatic test_random_traffic(input int item_count, input int sender_pct,
                                      input int receiver_pct);
      logic [KEY_W-1:0]   key_pool [8];
      logic [KEY_W-1:0]   key;
      logic [LEVEL_W-1:0] note;
      int                 sent;
      int                 hold;
      int                 fade;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      write_setting(CSR_ATTACK, pick_setting());
      write_setting(CSR_DECAY, pick_setting());
      write_setting(CSR_RELEASE, pick_setting());
      foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(0, 255));
      sent = 0;
      while (sent < item_count) begin
         if ($urandom_range(0, 9) < 2) begin
            send_frame(KEY_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)),
                       TIME_W'($urandom_range(0, 65535)));
            sent++;
         end else begin
            key  = ($urandom_range(0, 9) < 7) ? key_pool[3'($urandom_range(0, 7))]
                                               : KEY_W'($urandom_range(0, 255));
            note = LEVEL_W'($urandom_range(1, 255));
            hold = $urandom_range(1, 14);
            fade = $urandom_range(1, 14);
            repeat (hold) begin
               if ($urandom_range(0, 1) == 0) send_frame(key, note, pick_frame_time());
               else send_frame(key, LEVEL_W'($urandom_range(1, 255)), pick_frame_time());
            end
            // Key released, with the odd retrigger.
            repeat (fade) begin
               if ($urandom_range(0, 19) == 0) send_frame(key, LEVEL_W'($urandom_range(1, 255)),
                                                          pick_frame_time());
               else send_frame(key, 8'd0, pick_frame_time());
            end
            sent += hold + fade;
         end
      end
      drain_results();
   endtask

   // The receiver stalls at random on the falling edge.
   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Each accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin : check_results
      envelope_beat_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_beats.size() == 0) begin
            report_mismatch($sformatf("beat for key %0d with nothing expected",
                                      rsp_bus.key_echo));
         end else begin
            want = awaited_beats.pop_front();
            if (rsp_bus.key_echo !== want.key)
               report_mismatch($sformatf("key %0d, expected %0d", rsp_bus.key_echo, want.key));
            if (rsp_bus.brightness !== want.level)
               report_mismatch($sformatf("key %0d brightness %0d, expected %0d",
                                         want.key, rsp_bus.brightness, want.level));
            if (rsp_bus.envelope_phase !== want.phase)
               report_mismatch($sformatf("key %0d phase %0d, expected %0d",
                                         want.key, rsp_bus.envelope_phase, want.phase));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      req_bus.valid      = 1'b0;
      req_bus.key_index  = '0;
      req_bus.note_level = '0;
      req_bus.frame_time = '0;
      attack_set  = 8'd255;
      decay_set   = 8'd128;
      release_set = 8'd8;
      for (int i = 0; i < NUM_KEYS; i++) begin
         env_phase[i]    = PH_REST;
         env_velocity[i] = '0;
         env_level[i]    = '0;
      end
      send_idle_pct = 37;
      recv_idle_pct = 59;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_envelope();
      test_register_writes();
      test_random_traffic(125, 37, 59);
      test_random_traffic(125, 59, 37);
      test_random_traffic(125, 0, 0);

      // Give any stray beat time to show up.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
